/* rtl/core/ycbcr16_to_rgb8_convert_macros.svh */
// Assertion macros for the YCbCr to RGB converter.
`ifndef YCBCR16_TO_RGB8_CONVERT_MACROS_SVH
`define YCBCR16_TO_RGB8_CONVERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define Y2R_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define Y2R_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define Y2R_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define Y2R_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/y2r_pkg.sv */
// Shared widths, fixed-point coefficients and types for the YCbCr to RGB converter.
`default_nettype none

package y2r_pkg;

  // Sample and pixel widths.
  localparam int SampleW = 16;
  localparam int PixW    = 8;

  // Unsigned Q.20 coefficients and the width of one product.
  localparam int CoefW = 22;
  localparam int ProdW = CoefW + SampleW;

  // Signed Q.28 accumulator width.
  localparam int AccW = 41;

  localparam logic [CoefW-1:0] CoefY   = 22'd1220944;
  localparam logic [CoefW-1:0] CoefCrR = 22'd1673556;
  localparam logic [CoefW-1:0] CoefCbG = 22'd410792;
  localparam logic [CoefW-1:0] CoefCrG = 22'd852460;
  localparam logic [CoefW-1:0] CoefCbB = 22'd2115224;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [ProdW-1:0]       prod_t;
  typedef logic [SampleW-1:0]     sample_t;
  typedef logic [PixW-1:0]        pix_t;

  // Channel offsets in Q.28 with the rounding half already folded in.
  localparam acc_t RedBias   = acc_t'(64'sd134217728 - 64'sd913084 * 64'sd65536);
  localparam acc_t GreenBias = acc_t'(64'sd134217728 + 64'sd555319 * 64'sd65536);
  localparam acc_t BlueBias  = acc_t'(64'sd134217728 - 64'sd1133920 * 64'sd65536);

  // Bit position of the integer part in a Q.28 value.
  localparam int FracW = 28;

endpackage

`default_nettype wire

/* rtl/core/y2r_ycc_if.sv */
// Valid/ready channel that carries one YCbCr pixel.
`default_nettype none

interface y2r_ycc_if;
  import y2r_pkg::*;

  logic    valid;
  logic    ready;
  sample_t luma;
  sample_t chroma_blue;
  sample_t chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/y2r_rgb_if.sv */
// Valid/ready channel that carries one RGB pixel.
`default_nettype none

interface y2r_rgb_if;
  import y2r_pkg::*;

  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* rtl/core/ycbcr16_to_rgb8_convert.sv */
// An input transfer reaches the output channel through the stage registers in order.
// Throughput: one pixel per cycle; each stage moves whenever the stage after it
// is empty or moving, so bubbles close up and a stall holds every stage in place.
// Stages: products, biased sums, green second subtract, round and clip.
// Reset (rst, synchronous) clears the stage valid bits; data registers keep values.
`default_nettype none
`include "ycbcr16_to_rgb8_convert_macros.svh"

module ycbcr16_to_rgb8_convert (
  input wire logic clk,
  input wire logic rst,
  y2r_ycc_if.sink  ycc,
  y2r_rgb_if.source rgb
);
  import y2r_pkg::*;

  // Stage valid bits.
  logic v1, v2, v3, ov;
  logic en1, en2, en3, en4;

  // Stage 1: products.
  prod_t p_y, p_crr, p_cbg, p_crg, p_cbb;
  // Stage 2: biased partial sums.
  acc_t s2_r, s2_g, s2_b, s2_gc;
  // Stage 3: full sums.
  acc_t s3_r, s3_g, s3_b;
  // Saturated channels ahead of the output register.
  pix_t sat_r, sat_g, sat_b;
  pix_t red, green, blue;

  // Per-stage enables: a stage loads when it is empty or its successor moves.
  assign en4 = !ov || rgb.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign ycc.ready = en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1) v1 <= ycc.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) ov <= v3;
    end
  end

  // Stage 1: five coefficient products of unsigned samples.
  always_ff @(posedge clk) begin
    if (en1) begin
      p_y   <= CoefY   * ycc.luma;
      p_crr <= CoefCrR * ycc.chroma_red;
      p_cbg <= CoefCbG * ycc.chroma_blue;
      p_crg <= CoefCrG * ycc.chroma_red;
      p_cbb <= CoefCbB * ycc.chroma_blue;
    end
  end

  // Stage 2: luma term plus or minus one chroma term, plus the channel bias.
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r  <= acc_t'(p_y) + acc_t'(p_crr) + RedBias;
      s2_g  <= acc_t'(p_y) - acc_t'(p_cbg) + GreenBias;
      s2_b  <= acc_t'(p_y) + acc_t'(p_cbb) + BlueBias;
      s2_gc <= acc_t'(p_crg);
    end
  end

  // Stage 3: green takes its second chroma term.
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r <= s2_r;
      s3_g <= s2_g - s2_gc;
      s3_b <= s2_b;
    end
  end

  // Round and clip each channel.
  y2r_sat u_sat_r (.acc(s3_r), .pix(sat_r));
  y2r_sat u_sat_g (.acc(s3_g), .pix(sat_g));
  y2r_sat u_sat_b (.acc(s3_b), .pix(sat_b));

  // Output register.
  always_ff @(posedge clk) begin
    if (en4) begin
      red   <= sat_r;
      green <= sat_g;
      blue  <= sat_b;
    end
  end

  assign rgb.valid = ov;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

  // An accepted input transfer always lands in the first stage.
  `Y2R_ASSERT_NEXT(a_in_lands, clk, rst, ycc.valid && ycc.ready, v1, "input transfer lost")
  // An empty first stage never blocks the input.
  `Y2R_ASSERT_NOW(a_empty_ready, clk, rst, !v1, ycc.ready, "input blocked while stage 1 empty")
  // A blocked output keeps the item waiting in stage 3.
  `Y2R_ASSERT_NEXT(a_hold_s3, clk, rst, v3 && ov && !rgb.ready, v3, "stage 3 item dropped")
  // A taken result with nothing behind it leaves the output empty.
  `Y2R_ASSERT_NEXT(a_no_repeat, clk, rst, ov && rgb.ready && !v3, !rgb.valid,
                   "output transfer repeated")
endmodule

`default_nettype wire

/* rtl/core/y2r_sat.sv */
// Round-half-up and clip of a Q.28 sum (half already added) to an 8-bit channel.
`default_nettype none

module y2r_sat (
  input  y2r_pkg::acc_t acc,
  output y2r_pkg::pix_t pix
);
  import y2r_pkg::*;

  // A negative sum gives zero, any integer part above 255 gives full scale.
  always_comb begin
    if (acc[AccW-1]) begin
      pix = '0;
    end else if (|acc[AccW-2:FracW+PixW]) begin
      pix = '1;
    end else begin
      pix = acc[FracW+PixW-1:FracW];
    end
  end
endmodule

`default_nettype wire
